// ----- sv/sm3_pkg.sv -----
// Shared types, constants and functions for the SM3 hash engine.
// Used by the controller, the datapath and the top level; no dependencies.
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_MARK = 32'h80000000;
    localparam logic [3:0]  LAST_WORD = 4'd15;
    localparam logic [3:0]  LEN_HI_WORD = 4'd14;
    localparam logic [3:0]  LEN_LO_WORD = 4'd15;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [2:0]  LAST_INDEX = 3'd7;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        AF_IDLE,
        AF_PAD,
        AF_LEN,
        AF_OUT
    } after_t;

    typedef struct packed {
        logic       word_wr;
        logic       capture;
        logic       comp_load;
        logic       round;
        logic [5:0] rnd;
        logic       fold;
        logic       pad_wr;
        logic       len_wr;
        logic       len_clr;
        logic       msg_reset;
        logic [2:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic [3:0] fill_w;
        logic [3:0] pad_ptr;
    } sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] j);
        logic [31:0] t;
        t = (j < 6'd16) ? T_LOW : T_HIGH;
        return rotl(t, j[4:0]);
    endfunction

    function automatic logic [31:0] init_value(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0:    v = 32'h7380166F;
            3'd1:    v = 32'h4914B2B9;
            3'd2:    v = 32'h172442D7;
            3'd3:    v = 32'hDA8A0600;
            3'd4:    v = 32'hA96F30BC;
            3'd5:    v = 32'h163138AA;
            3'd6:    v = 32'hE38DEE4D;
            default: v = 32'hB0FB0E4E;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/sm3_ctrl.sv -----
// Controller state machine for the SM3 hash engine.
// Depends on sm3_pkg; drives the datapath through cmd_t and reads sts_t.
module sm3_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    input  logic [2:0]      valid_bytes,
    output logic            s_tready,
    output logic            m_tvalid,
    output logic            m_tlast,
    input  logic            m_tready,
    output logic [2:0]      word_index,
    input  sm3_pkg::sts_t   sts,
    output sm3_pkg::cmd_t   cmd
);

    sm3_pkg::state_t state_reg, state_next;
    sm3_pkg::after_t after_reg, after_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       clr_reg, clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm3_pkg::ST_IDLE;
            after_reg <= sm3_pkg::AF_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            clr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        cmd.rnd    = rnd_reg;
        cmd.out_idx = idx_reg;
        cmd.len_clr = clr_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        word_index = idx_reg;
        case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!s_tlast)
                    begin
                        cmd.word_wr = 1'b1;
                        if (sts.fill_w == sm3_pkg::LAST_WORD)
                        begin
                            cmd.comp_load = 1'b1;
                            rnd_next   = '0;
                            after_next = sm3_pkg::AF_IDLE;
                            state_next = sm3_pkg::ST_ROUND;
                        end
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        if (valid_bytes >= sm3_pkg::FULL_BYTES)
                        begin
                            cmd.word_wr = 1'b1;
                            if (sts.fill_w == sm3_pkg::LAST_WORD)
                            begin
                                cmd.comp_load = 1'b1;
                                rnd_next   = '0;
                                after_next = sm3_pkg::AF_PAD;
                                state_next = sm3_pkg::ST_ROUND;
                            end
                            else
                            begin
                                state_next = sm3_pkg::ST_PAD;
                            end
                        end
                        else
                        begin
                            state_next = sm3_pkg::ST_PAD;
                        end
                    end
                end
            end
            sm3_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == sm3_pkg::LAST_ROUND)
                begin
                    state_next = sm3_pkg::ST_FOLD;
                end
            end
            sm3_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
                case (after_reg)
                    sm3_pkg::AF_PAD: state_next = sm3_pkg::ST_PAD;
                    sm3_pkg::AF_LEN: state_next = sm3_pkg::ST_LEN;
                    sm3_pkg::AF_OUT:
                    begin
                        idx_next   = '0;
                        state_next = sm3_pkg::ST_OUT;
                    end
                    default: state_next = sm3_pkg::ST_IDLE;
                endcase
            end
            sm3_pkg::ST_PAD:
            begin
                cmd.pad_wr = 1'b1;
                if (sts.pad_ptr >= sm3_pkg::LEN_HI_WORD)
                begin
                    // length no longer fits: compress this block, then a clean one
                    clr_next      = 1'b1;
                    cmd.comp_load = 1'b1;
                    rnd_next      = '0;
                    after_next    = sm3_pkg::AF_LEN;
                    state_next    = sm3_pkg::ST_ROUND;
                end
                else
                begin
                    clr_next   = 1'b0;
                    state_next = sm3_pkg::ST_LEN;
                end
            end
            sm3_pkg::ST_LEN:
            begin
                cmd.len_wr    = 1'b1;
                cmd.comp_load = 1'b1;
                rnd_next      = '0;
                after_next    = sm3_pkg::AF_OUT;
                state_next    = sm3_pkg::ST_ROUND;
            end
            sm3_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = (idx_reg == sm3_pkg::LAST_INDEX);
                if (m_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sm3_pkg::LAST_INDEX)
                    begin
                        cmd.msg_reset = 1'b1;
                        state_next    = sm3_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sm3_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- sv/sm3_datapath.sv -----
// Datapath of the SM3 hash engine: block buffer, message schedule, round unit, chain.
// Depends on sm3_pkg; driven by sm3_ctrl through cmd_t.
module sm3_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     message_word,
    input  logic [2:0]      valid_bytes,
    input  sm3_pkg::cmd_t   cmd,
    output sm3_pkg::sts_t   sts,
    output logic [31:0]     digest_word
);

    logic [31:0] buf_reg [16];
    logic [31:0] buf_next [16];
    logic [31:0] win_reg [16];
    logic [31:0] wk_reg  [8];
    logic [31:0] chain_reg [8];
    logic [3:0]  fill_reg;
    logic [54:0] count_reg;
    logic [3:0]  ptr_reg;
    logic [31:0] pw_reg;
    logic [63:0] bits_reg;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnext;
    logic [6:0]  byte_sum;
    logic [2:0]  vcnt;
    logic [31:0] pw_next;

    assign sts.fill_w  = fill_reg;
    assign sts.pad_ptr = ptr_reg;
    assign digest_word = chain_reg[cmd.out_idx];

    // byte count and pad word of the final word
    always_comb
    begin
        vcnt = (valid_bytes >= sm3_pkg::FULL_BYTES) ? sm3_pkg::FULL_BYTES : valid_bytes;
        byte_sum = {1'b0, fill_reg, 2'b00} + {4'b0000, vcnt};
        case (vcnt)
            3'd1:    pw_next = {message_word[31:24], 24'h800000};
            3'd2:    pw_next = {message_word[31:16], 16'h8000};
            3'd3:    pw_next = {message_word[31:8], 8'h80};
            default: pw_next = sm3_pkg::PAD_MARK;
        endcase
    end

    // one compression round
    always_comb
    begin
        a12 = sm3_pkg::rotl(wk_reg[0], 5'd12);
        ss1 = sm3_pkg::rotl(a12 + wk_reg[4] + sm3_pkg::round_const(cmd.rnd), 5'd7);
        ss2 = ss1 ^ a12;
        if (cmd.rnd < 6'd16)
        begin
            ff = wk_reg[0] ^ wk_reg[1] ^ wk_reg[2];
            gg = wk_reg[4] ^ wk_reg[5] ^ wk_reg[6];
        end
        else
        begin
            ff = (wk_reg[0] & wk_reg[1]) | (wk_reg[0] & wk_reg[2]) | (wk_reg[1] & wk_reg[2]);
            gg = (wk_reg[4] & wk_reg[5]) | (~wk_reg[4] & wk_reg[6]);
        end
        tt1 = ff + wk_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + wk_reg[7] + ss1 + win_reg[0];
        wnext = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 5'd15))
              ^ sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // next block contents, so that a load in the same cycle sees the new word
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            buf_next[i] = buf_reg[i];
            if (cmd.word_wr)
            begin
                if (4'(i) == fill_reg)
                    buf_next[i] = message_word;
            end
            else if (cmd.pad_wr)
            begin
                if (4'(i) == ptr_reg)
                    buf_next[i] = pw_reg;
                else if (4'(i) > ptr_reg)
                    buf_next[i] = '0;
            end
            else if (cmd.len_wr)
            begin
                if (4'(i) == sm3_pkg::LEN_HI_WORD)
                    buf_next[i] = bits_reg[63:32];
                else if (4'(i) == sm3_pkg::LEN_LO_WORD)
                    buf_next[i] = bits_reg[31:0];
                else if (cmd.len_clr)
                    buf_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
            buf_reg[i] <= buf_next[i];

        if (cmd.comp_load)
        begin
            for (int i = 0; i < 16; i++)
                win_reg[i] <= buf_next[i];
            for (int i = 0; i < 8; i++)
                wk_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= wnext;
            wk_reg[0] <= tt1;
            wk_reg[1] <= wk_reg[0];
            wk_reg[2] <= sm3_pkg::rotl(wk_reg[1], 5'd9);
            wk_reg[3] <= wk_reg[2];
            wk_reg[4] <= sm3_pkg::perm0(tt2);
            wk_reg[5] <= wk_reg[4];
            wk_reg[6] <= sm3_pkg::rotl(wk_reg[5], 5'd19);
            wk_reg[7] <= wk_reg[6];
        end

        if (cmd.capture)
        begin
            pw_reg   <= pw_next;
            ptr_reg  <= (vcnt == sm3_pkg::FULL_BYTES) ? fill_reg + 4'd1 : fill_reg;
            bits_reg <= {count_reg, 9'b0} + {54'b0, byte_sum, 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sm3_pkg::init_value(3'(i));
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.msg_reset)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= sm3_pkg::init_value(3'(i));
                fill_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.fold)
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] ^ wk_reg[i];
                end
                if (cmd.word_wr)
                begin
                    fill_reg <= fill_reg + 4'd1;
                    if (fill_reg == sm3_pkg::LAST_WORD)
                        count_reg <= count_reg + 55'd1;
                end
            end
        end
    end

endmodule

// ----- sv/sm3_hash_engine_core.sv -----
// SM3 hash engine top level: stream ports, controller and datapath.
// Depends on sm3_pkg, sm3_ctrl and sm3_datapath.
// A word that does not complete a block is accepted in the idle state; a word that
// completes a block stops input while the block is compressed: load with the accept,
// 64 rounds in the single round unit, one fold. A final word leads to one or two
// extra blocks before the first digest word, then 8 words at one per accepted cycle.
// Reset clears the controller and loads the SM3 initial value; no clearing pass.
module sm3_hash_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [31:0] message_word, [34:32] valid_bytes, zero above
    input  logic        s_tlast,  // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, zero above
    output logic        m_tlast   // last_of_digest
);

    sm3_pkg::cmd_t cmd;
    sm3_pkg::sts_t sts;
    logic [2:0]  word_index;
    logic [31:0] digest_word;

    // sequencing: absorb, pad, length, compress and hand out the digest
    sm3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tlast     (s_tlast),
        .valid_bytes (s_tdata[34:32]),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tlast     (m_tlast),
        .m_tready    (m_tready),
        .word_index  (word_index),
        .sts         (sts),
        .cmd         (cmd)
    );

    // storage and the round unit
    sm3_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .message_word (s_tdata[31:0]),
        .valid_bytes  (s_tdata[34:32]),
        .cmd          (cmd),
        .sts          (sts),
        .digest_word  (digest_word)
    );

    // drive the digest word straight from the chain registers
    assign m_tdata = {5'b00000, word_index, digest_word};

endmodule

// ----- sv/sm3_checker.sv -----
// Port-level checker for the SM3 hash engine, bound to the top level.
// Depends on sm3_hash_engine_core ports only.
module sm3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // hold a stalled digest word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("digest word changed while stalled");

    // never take input while the digest is being handed out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    // the last digest word sits at index seven
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[34:32] == 3'd7)
        else $error("last flag on wrong index");

    // a final word stops input until the digest is out
    a_final_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after final word");

    // drop valid after the last digest word
    a_end_digest: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("digest words continue past the last");

endmodule

bind sm3_hash_engine_core sm3_checker u_sm3_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
